>>> hdl/dcf_pkg.sv
// dcf_pkg: types and constants for the door controller.
// Shared by dcf_step and door_controller_fsm; no dependencies.
`timescale 1ns / 1ps

package dcf_pkg;

	typedef enum logic [2:0] {
		DOOR_CLOSED  = 3'd0,
		DOOR_OPENING = 3'd1,
		DOOR_OPEN    = 3'd2,
		DOOR_CLOSING = 3'd3,
		DOOR_STOPOP  = 3'd4,
		DOOR_STOPCL  = 3'd5,
		DOOR_FORCED  = 3'd6
	} door_mode_t;

	typedef enum logic [3:0] {
		MSG_NONE       = 4'd0,
		MSG_OPENED     = 4'd1,
		MSG_CLOSED     = 4'd2,
		MSG_CLOSING    = 4'd3,
		MSG_OPENING    = 4'd4,
		MSG_STOP_OPEN  = 4'd5,
		MSG_STOP_CLOSE = 4'd6,
		MSG_FORCED     = 4'd7,
		MSG_OBSTRUCTED = 4'd8
	} msg_t;

	typedef enum logic [1:0] {
		KIND_TICK   = 2'd0,
		KIND_CMD    = 2'd1,
		KIND_SAMPLE = 2'd2
	} kind_t;

	typedef enum logic {
		REG_TRAVEL_TICKS = 1'b0,
		REG_DEBOUNCE     = 1'b1
	} reg_idx_t;

	localparam int TRAVEL_W = 8;
	localparam int DEB_W    = 16;
	localparam int CFG_W    = 16;

	localparam logic [TRAVEL_W-1:0] TRAVEL_TICKS_RST = 8'd12;
	localparam logic [DEB_W-1:0]    DEBOUNCE_RST     = 16'd5000;

	typedef struct packed {
		door_mode_t          mode;
		logic [TRAVEL_W-1:0] travel;
		logic                red;
		logic                green;
		logic                qualifying;
		logic [DEB_W-1:0]    stable;
		logic [DEB_W-1:0]    noise;
		logic                last_level;
	} ctl_state_t;

	localparam ctl_state_t CTL_STATE_RST = '{
		mode:       DOOR_CLOSED,
		travel:     '0,
		red:        1'b0,
		green:      1'b1,
		qualifying: 1'b0,
		stable:     '0,
		noise:      '0,
		last_level: 1'b1
	};

endpackage

>>> hdl/dcf_step.sv
// dcf_step: next-state and message logic for one door controller beat.
// Purely combinational; depends on dcf_pkg.
`timescale 1ns / 1ps

module dcf_step (
	input  dcf_pkg::ctl_state_t            cur,
	input  logic [1:0]                     kind,
	input  logic                           level,
	input  logic [dcf_pkg::TRAVEL_W-1:0]   travel_ticks,
	input  logic [dcf_pkg::DEB_W-1:0]      debounce_samples,
	output dcf_pkg::ctl_state_t            nxt,
	output dcf_pkg::msg_t                  msg
);

	logic [dcf_pkg::TRAVEL_W:0]   travel_inc;
	logic [dcf_pkg::TRAVEL_W-1:0] travel_dec;
	logic                         open_reach;
	logic                         close_reach;
	logic                         deb_start;
	logic                         deb_active;
	logic [dcf_pkg::DEB_W-1:0]    stable_base;
	logic [dcf_pkg::DEB_W-1:0]    noise_base;
	logic [dcf_pkg::DEB_W-1:0]    stable_new;
	logic [dcf_pkg::DEB_W-1:0]    noise_new;
	logic                         deb_confirm;
	logic                         deb_abort;
	logic                         in_travel;

	assign travel_inc  = {1'b0, cur.travel} + 1'b1;
	assign open_reach  = travel_inc >= {1'b0, travel_ticks};
	assign travel_dec  = (cur.travel != '0) ? cur.travel - 1'b1 : cur.travel;
	assign close_reach = travel_dec == '0;
	assign in_travel   = (cur.mode == dcf_pkg::DOOR_OPENING) ||
	                     (cur.mode == dcf_pkg::DOOR_CLOSING);

	// falling edge on the raw line opens a qualification run
	assign deb_start   = !cur.qualifying && cur.last_level && !level;
	assign deb_active  = cur.qualifying || deb_start;
	assign stable_base = deb_start ? '0 : cur.stable;
	assign noise_base  = deb_start ? '0 : cur.noise;

	always_comb begin
		stable_new = stable_base;
		noise_new  = noise_base;
		if (stable_base < debounce_samples) begin
			stable_new = stable_base + 1'b1;
		end
		if (level) begin
			stable_new = '0;
			noise_new  = noise_base + 1'b1;
		end
	end

	assign deb_confirm = deb_active && (stable_new >= debounce_samples);
	assign deb_abort   = deb_active && !deb_confirm && (noise_new >= debounce_samples);

	// next state
	always_comb begin
		nxt = cur;
		unique case (kind)
			dcf_pkg::KIND_TICK: begin
				unique case (cur.mode)
					dcf_pkg::DOOR_OPEN: begin
						nxt.red   = 1'b1;
						nxt.green = 1'b1;
					end
					dcf_pkg::DOOR_CLOSED: begin
						nxt.red   = 1'b0;
						nxt.green = 1'b0;
					end
					dcf_pkg::DOOR_OPENING: begin
						nxt.red   = 1'b0;
						nxt.green = 1'b1;
						if (open_reach) begin
							nxt.mode   = dcf_pkg::DOOR_OPEN;
							nxt.travel = travel_ticks;
						end else begin
							nxt.travel = travel_inc[dcf_pkg::TRAVEL_W-1:0];
						end
					end
					dcf_pkg::DOOR_CLOSING: begin
						nxt.red    = 1'b1;
						nxt.green  = 1'b0;
						nxt.travel = travel_dec;
						if (close_reach) begin
							nxt.mode = dcf_pkg::DOOR_CLOSED;
						end
					end
					dcf_pkg::DOOR_STOPOP: begin
						nxt.red   = 1'b0;
						nxt.green = !cur.green;
					end
					dcf_pkg::DOOR_STOPCL: begin
						nxt.green = 1'b0;
						nxt.red   = !cur.red;
					end
					dcf_pkg::DOOR_FORCED: begin
						nxt.red   = 1'b1;
						nxt.green = !cur.green;
					end
					default: ;
				endcase
			end
			dcf_pkg::KIND_CMD: begin
				unique case (cur.mode)
					dcf_pkg::DOOR_OPEN,
					dcf_pkg::DOOR_STOPOP:  nxt.mode = dcf_pkg::DOOR_CLOSING;
					dcf_pkg::DOOR_CLOSED,
					dcf_pkg::DOOR_STOPCL,
					dcf_pkg::DOOR_FORCED:  nxt.mode = dcf_pkg::DOOR_OPENING;
					dcf_pkg::DOOR_OPENING: nxt.mode = dcf_pkg::DOOR_STOPOP;
					dcf_pkg::DOOR_CLOSING: nxt.mode = dcf_pkg::DOOR_STOPCL;
					default: ;
				endcase
			end
			dcf_pkg::KIND_SAMPLE: begin
				nxt.last_level = level;
				if (deb_active) begin
					nxt.qualifying = !(deb_confirm || deb_abort);
					nxt.stable     = stable_new;
					nxt.noise      = noise_new;
				end
				if (deb_confirm && in_travel) begin
					nxt.mode = dcf_pkg::DOOR_FORCED;
				end
			end
			default: ;
		endcase
	end

	// message
	always_comb begin
		msg = dcf_pkg::MSG_NONE;
		unique case (kind)
			dcf_pkg::KIND_TICK: begin
				if (cur.mode == dcf_pkg::DOOR_OPENING && open_reach) begin
					msg = dcf_pkg::MSG_OPENED;
				end else if (cur.mode == dcf_pkg::DOOR_CLOSING && close_reach) begin
					msg = dcf_pkg::MSG_CLOSED;
				end
			end
			dcf_pkg::KIND_CMD: begin
				unique case (cur.mode)
					dcf_pkg::DOOR_OPEN,
					dcf_pkg::DOOR_STOPOP:  msg = dcf_pkg::MSG_CLOSING;
					dcf_pkg::DOOR_CLOSED,
					dcf_pkg::DOOR_STOPCL:  msg = dcf_pkg::MSG_OPENING;
					dcf_pkg::DOOR_OPENING: msg = dcf_pkg::MSG_STOP_OPEN;
					dcf_pkg::DOOR_CLOSING: msg = dcf_pkg::MSG_STOP_CLOSE;
					dcf_pkg::DOOR_FORCED:  msg = dcf_pkg::MSG_FORCED;
					default: ;
				endcase
			end
			dcf_pkg::KIND_SAMPLE: begin
				if (deb_confirm && in_travel) begin
					msg = dcf_pkg::MSG_OBSTRUCTED;
				end
			end
			default: ;
		endcase
	end

endmodule

>>> hdl/door_controller_fsm.sv
// door_controller_fsm: door controller top level with stream ports and register writes.
// Depends on dcf_pkg and dcf_step.
`timescale 1ns / 1ps

// Usage:
//   s_axis carries one event per beat: tuser holds the kind (tick, command,
//   button sample), tdata bit 0 holds the raw button level (0 = pressed).
//   m_axis returns exactly one result beat per event: message code, door
//   state and both lamp drives.
//   cfg_we/cfg_index/cfg_wdata write travel_ticks (index 0) and
//   debounce_samples (index 1); write only when no beat is in flight.
// Path: an accepted event is held in the input register, then the result
//   register presents its result on m_axis.
// Throughput: one event per cycle while m_axis_tready is high; the whole door and
//   debounce update is one pass of logic between the input and result registers.
// Stall: while m_axis_tready is low the result register holds, the input
//   register still takes one more beat, then s_axis_tready drops until the
//   result is taken.
// Reset: door closed, travel count zero, red off, green on, no debounce
//   run, button seen released, registers at 12 ticks and 5000 samples.

module door_controller_fsm (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [0] button_level, [7:1] zero
	input  logic [1:0]  s_axis_tuser,   // [1:0] kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [3:0] message, [6:4] door_state_out,
	                                    // [7] red_lamp, [8] green_lamp, [15:9] zero
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata
);

	logic                            item_valid_s1;
	logic [1:0]                      kind_s1;
	logic                            level_s1;
	logic                            out_valid_q;
	logic [15:0]                     out_data_q;
	logic                            fire;
	logic [dcf_pkg::TRAVEL_W-1:0]    travel_ticks_q;
	logic [dcf_pkg::DEB_W-1:0]       debounce_q;
	dcf_pkg::ctl_state_t             state_q;
	dcf_pkg::ctl_state_t             state_nxt;
	dcf_pkg::msg_t                   msg;

	assign fire          = item_valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !item_valid_s1 || fire;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			travel_ticks_q <= dcf_pkg::TRAVEL_TICKS_RST;
			debounce_q     <= dcf_pkg::DEBOUNCE_RST;
		end else if (cfg_we) begin
			unique case (dcf_pkg::reg_idx_t'(cfg_index))
				dcf_pkg::REG_TRAVEL_TICKS: travel_ticks_q <= cfg_wdata[dcf_pkg::TRAVEL_W-1:0];
				dcf_pkg::REG_DEBOUNCE:     debounce_q     <= cfg_wdata[dcf_pkg::DEB_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			item_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			kind_s1  <= s_axis_tuser;
			level_s1 <= s_axis_tdata[0];
		end
	end

	dcf_step u_step (
		.cur              (state_q),
		.kind             (kind_s1),
		.level            (level_s1),
		.travel_ticks     (travel_ticks_q),
		.debounce_samples (debounce_q),
		.nxt              (state_nxt),
		.msg              (msg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dcf_pkg::CTL_STATE_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				state_q <= state_nxt;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= {7'd0, state_nxt.green, state_nxt.red, state_nxt.mode, msg};
		end
	end

endmodule
